// ===== design/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the block clock, off during reset.
`define CBS_ASSERT_IMP(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("coverage summarizer check failed");

// Next-cycle implication, sampled on the block clock, off during reset.
`define CBS_ASSERT_NXT(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("coverage summarizer check failed");

`endif

// ===== design/cbs_pkg.sv =====
package cbs_pkg;

   localparam int LANES      = 8;
   localparam int BYTE_W     = 8;
   localparam int WORD_W     = 64;
   localparam int POS_W      = 13;
   localparam int IDX_W      = 16;
   localparam int CNT_W      = 17;
   localparam int LANE_CNT_W = $clog2(LANES + 1);

   localparam logic [BYTE_W-1:0] VIRGIN_BYTE = 8'hFF;
   localparam logic [CNT_W-1:0]  CNT_MAX     = {CNT_W{1'b1}};

   // what one lane finds in its byte pair
   typedef struct packed {
      logic              covered;
      logic              fresh;
      logic [BYTE_W-1:0] heat;
   } lane_result_type;

   // one word boiled down by the merge stage
   typedef struct packed {
      logic                  last;
      logic [LANE_CNT_W-1:0] covered_n;
      logic                  fresh_found;
      logic [IDX_W-1:0]      fresh_index;
      logic [BYTE_W-1:0]     hot_value;
      logic [IDX_W-1:0]      hot_index;
   } word_summary_type;

endpackage

// ===== design/cbs_if.sv =====
interface cbs_req_if;
   logic                       valid;
   logic                       ready;
   logic [cbs_pkg::WORD_W-1:0] trace_word;
   logic [cbs_pkg::WORD_W-1:0] virgin_word;
   logic                       last_word;

   modport source (output valid, output trace_word, output virgin_word, output last_word,
                   input ready);
   modport sink   (input valid, input trace_word, input virgin_word, input last_word,
                   output ready);
endinterface

interface cbs_rsp_if;
   logic                      valid;
   logic                      ready;
   logic [cbs_pkg::IDX_W-1:0] edge_index;
   logic [cbs_pkg::CNT_W-1:0] covered_entries;
   logic [cbs_pkg::CNT_W-1:0] new_coverage;

   modport source (output valid, output edge_index, output covered_entries,
                   output new_coverage, input ready);
   modport sink   (input valid, input edge_index, input covered_entries,
                   input new_coverage, output ready);
endinterface

// ===== design/cbs_lane.sv =====
module cbs_lane (
   input  logic [cbs_pkg::BYTE_W-1:0] trace_byte,
   input  logic [cbs_pkg::BYTE_W-1:0] virgin_byte,
   input  logic [cbs_pkg::IDX_W-1:0]  entry_index,
   output cbs_pkg::lane_result_type   result
);

   logic is_virgin;
   logic index_ok;

   assign is_virgin = (virgin_byte == cbs_pkg::VIRGIN_BYTE);
   // entry 0 still counts but never takes part in the edge search
   assign index_ok  = (entry_index != '0);

   always_comb begin
      result.covered = !is_virgin;
      result.fresh   = index_ok && is_virgin && (trace_byte != '0);
      result.heat    = index_ok ? trace_byte : '0;
   end

endmodule

// ===== design/cbs_merge.sv =====
module cbs_merge (
   input  logic                      clock,
   input  logic                      reset,
   cbs_req_if.sink                   req_chan,
   input  logic                      sum_take,
   output logic                      sum_valid,
   output cbs_pkg::word_summary_type summary
);

   logic                              sum_valid_ff, sum_valid_in;
   cbs_pkg::word_summary_type         summary_ff, summary_in;
   logic [cbs_pkg::POS_W-1:0]         pos_ff, pos_in;
   logic                              accept;
   logic [cbs_pkg::IDX_W-1:0]         entry_index [cbs_pkg::LANES];
   cbs_pkg::lane_result_type          lane_res    [cbs_pkg::LANES];

   assign req_chan.ready = !sum_valid_ff || sum_take;
   assign accept         = req_chan.valid && req_chan.ready;

   for (genvar k = 0; k < cbs_pkg::LANES; k++) begin : g_lane
      assign entry_index[k] =
         cbs_pkg::IDX_W'(int'(pos_ff) * cbs_pkg::LANES + k);

      cbs_lane u_lane (
         .trace_byte  (req_chan.trace_word[cbs_pkg::BYTE_W*k +: cbs_pkg::BYTE_W]),
         .virgin_byte (req_chan.virgin_word[cbs_pkg::BYTE_W*k +: cbs_pkg::BYTE_W]),
         .entry_index (entry_index[k]),
         .result      (lane_res[k])
      );
   end

   // later lanes win for newest; strictly larger heat wins for hottest
   always_comb begin
      summary_in = '0;
      summary_in.last = req_chan.last_word;
      for (int k = 0; k < cbs_pkg::LANES; k++) begin
         summary_in.covered_n = summary_in.covered_n
                              + cbs_pkg::LANE_CNT_W'(lane_res[k].covered);
         if (lane_res[k].fresh) begin
            summary_in.fresh_found = 1'b1;
            summary_in.fresh_index = entry_index[k];
         end
         if (lane_res[k].heat > summary_in.hot_value) begin
            summary_in.hot_value = lane_res[k].heat;
            summary_in.hot_index = entry_index[k];
         end
      end
   end

   always_comb begin
      pos_in       = pos_ff;
      sum_valid_in = sum_valid_ff;
      if (sum_take) sum_valid_in = 1'b0;
      if (accept) begin
         sum_valid_in = 1'b1;
         pos_in       = req_chan.last_word ? '0 : pos_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_valid_ff <= 1'b0;
         pos_ff       <= '0;
      end else begin
         sum_valid_ff <= sum_valid_in;
         pos_ff       <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) summary_ff <= summary_in;
   end

   assign sum_valid = sum_valid_ff;
   assign summary   = summary_ff;

endmodule

// ===== design/cbs_accum.sv =====
`include "assert_macros.svh"

module cbs_accum (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      sum_valid,
   input  cbs_pkg::word_summary_type summary,
   output logic                      sum_take,
   cbs_rsp_if.source                 rsp_chan
);

   logic [cbs_pkg::CNT_W-1:0]  count_ff, count_in;
   logic                       found_ff, found_in;
   logic [cbs_pkg::IDX_W-1:0]  newest_ff, newest_in;
   logic [cbs_pkg::BYTE_W-1:0] hot_val_ff, hot_val_in;
   logic [cbs_pkg::IDX_W-1:0]  hot_idx_ff, hot_idx_in;
   logic [cbs_pkg::CNT_W-1:0]  prev_ff, prev_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [cbs_pkg::IDX_W-1:0]  edge_ff, edge_in;
   logic [cbs_pkg::CNT_W-1:0]  covered_ff, covered_in;
   logic [cbs_pkg::CNT_W-1:0]  newcov_ff, newcov_in;
   logic [cbs_pkg::CNT_W:0]    count_sum;
   logic [cbs_pkg::CNT_W-1:0]  count_next;
   logic                       emit;

   assign sum_take = sum_valid && (!summary.last || !rsp_valid_ff || rsp_chan.ready);
   assign emit     = sum_take && summary.last;

   // saturating add of this word's covered lanes
   assign count_sum  = {1'b0, count_ff} + (cbs_pkg::CNT_W+1)'(summary.covered_n);
   assign count_next = count_sum[cbs_pkg::CNT_W] ? cbs_pkg::CNT_MAX
                                                 : count_sum[cbs_pkg::CNT_W-1:0];

   always_comb begin
      found_in   = found_ff;
      newest_in  = newest_ff;
      hot_val_in = hot_val_ff;
      hot_idx_in = hot_idx_ff;
      count_in   = count_ff;
      prev_in    = prev_ff;
      if (sum_take) begin
         count_in = count_next;
         if (summary.fresh_found) begin
            found_in  = 1'b1;
            newest_in = summary.fresh_index;
         end
         if (summary.hot_value > hot_val_ff) begin
            hot_val_in = summary.hot_value;
            hot_idx_in = summary.hot_index;
         end
      end
      edge_in    = found_in ? newest_in : hot_idx_in;
      covered_in = count_next;
      newcov_in  = (count_next > prev_ff) ? count_next - prev_ff : '0;
      if (emit) begin
         prev_in    = count_next;
         count_in   = '0;
         found_in   = 1'b0;
         hot_val_in = '0;
         hot_idx_in = '0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (rsp_chan.ready) rsp_valid_in = 1'b0;
      if (emit)           rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         found_ff     <= 1'b0;
         newest_ff    <= '0;
         hot_val_ff   <= '0;
         hot_idx_ff   <= '0;
         prev_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         found_ff     <= found_in;
         newest_ff    <= newest_in;
         hot_val_ff   <= hot_val_in;
         hot_idx_ff   <= hot_idx_in;
         prev_ff      <= prev_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         edge_ff    <= edge_in;
         covered_ff <= covered_in;
         newcov_ff  <= newcov_in;
      end
   end

   assign rsp_chan.valid           = rsp_valid_ff;
   assign rsp_chan.edge_index      = edge_ff;
   assign rsp_chan.covered_entries = covered_ff;
   assign rsp_chan.new_coverage    = newcov_ff;

   // a result only appears after a last word left the merge stage
   `CBS_ASSERT_IMP(a_rsp_from_last, $rose(rsp_valid_ff), $past(emit))
   // the scan state is clean once a last word has been taken in
   `CBS_ASSERT_NXT(a_scan_cleared, emit, count_ff == '0 && !found_ff && hot_val_ff == '0)
   // increase can never exceed the count it was taken from
   `CBS_ASSERT_IMP(a_newcov_bound, rsp_valid_ff, newcov_ff <= covered_ff)

endmodule

// ===== design/coverage_bitmap_summarizer.sv =====
// channel   | dir | payload                                        | handshake
// ----------+-----+------------------------------------------------+-------------
// req_chan  | in  | trace_word, virgin_word, last_word             | valid/ready
// rsp_chan  | out | edge_index, covered_entries, new_coverage      | valid/ready
//
// One map word per clock sustained while no result stalls; an item passes the lane merge
// register, then the accumulator's result register, before its result shows.
// Rate is set by the per-word accumulator loop: count, newest and hottest update once a clock.
// Synchronous active-high reset clears scan state, saved count and both valid flags.
// A stalled result holds back a last word and all words after it; words before it still flow.
module coverage_bitmap_summarizer (
   input  logic       clock,
   input  logic       reset,
   cbs_req_if.sink    req_chan,
   cbs_rsp_if.source  rsp_chan
);

   // word summary between the lane stage and the accumulator
   logic                      sum_valid;
   logic                      sum_take;
   cbs_pkg::word_summary_type summary;

   // LANES byte pairs checked side by side, merged into one registered summary;
   // also holds the word position counter that numbers the entries
   cbs_merge u_merge (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .sum_take  (sum_take),
      .sum_valid (sum_valid),
      .summary   (summary)
   );

   // running count, newest and hottest edge; emits and clears on a last word
   cbs_accum u_accum (
      .clock     (clock),
      .reset     (reset),
      .sum_valid (sum_valid),
      .summary   (summary),
      .sum_take  (sum_take),
      .rsp_chan  (rsp_chan)
   );

endmodule
